@@ src/chacha_pkg.sv @@
// Shared types, constants and functions for the ChaCha20 stream cipher.
// Used by chacha_cfg, chacha_core and chacha20_stream_cipher; no dependencies.
package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;

  // ChaCha constants "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2  = 3'd5;
  localparam logic [2:0] REG_INITCTR = 3'd6;

  // Word lanes of the eight quarter rounds: four columns, then four diagonals
  localparam logic [3:0] QR_LANES [8][4] = '{
    '{4'd0, 4'd4, 4'd8,  4'd12}, '{4'd1, 4'd5, 4'd9,  4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8,  4'd13}, '{4'd3, 4'd4, 4'd9,  4'd14}
  };

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [63:0] key01;
    logic [63:0] key23;
    logic [63:0] key45;
    logic [63:0] key67;
    logic [63:0] nonce01;
    logic [31:0] nonce2;
    logic [31:0] init_ctr;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] counter;
  } gen_req_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] data;
  } ks_wr_t;

  // Build the input state of one block
  function automatic block_t init_block(cfg_t c, logic [31:0] ctr);
    block_t b;
    b[0]  = SIGMA0;           b[1]  = SIGMA1;
    b[2]  = SIGMA2;           b[3]  = SIGMA3;
    b[4]  = c.key01[31:0];    b[5]  = c.key01[63:32];
    b[6]  = c.key23[31:0];    b[7]  = c.key23[63:32];
    b[8]  = c.key45[31:0];    b[9]  = c.key45[63:32];
    b[10] = c.key67[31:0];    b[11] = c.key67[63:32];
    b[12] = ctr;
    b[13] = c.nonce01[31:0];  b[14] = c.nonce01[63:32];
    b[15] = c.nonce2;
    return b;
  endfunction

  // One half of a quarter round: rotations 16/12 first, 8/7 second
  function automatic logic [127:0] qr_half(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d,
                                           logic second);
    logic [31:0] a1, b1, c1, d1, dx, bx;
    a1 = a + b;
    dx = d ^ a1;
    d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c1 = c + d1;
    bx = b ^ c1;
    b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
    return {a1, b1, c1, d1};
  endfunction

endpackage

@@ src/chacha_cfg.sv @@
// Configuration register file behind an APB-style port.
// Depends on chacha_pkg for the register indexes and the cfg_t bundle.
module chacha_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output chacha_pkg::cfg_t    cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        chacha_pkg::REG_KEY01:   cfg.key01    <= pwdata;
        chacha_pkg::REG_KEY23:   cfg.key23    <= pwdata;
        chacha_pkg::REG_KEY45:   cfg.key45    <= pwdata;
        chacha_pkg::REG_KEY67:   cfg.key67    <= pwdata;
        chacha_pkg::REG_NONCE01: cfg.nonce01  <= pwdata;
        chacha_pkg::REG_NONCE2:  cfg.nonce2   <= pwdata[31:0];
        chacha_pkg::REG_INITCTR: cfg.init_ctr <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      chacha_pkg::REG_KEY01:   prdata = cfg.key01;
      chacha_pkg::REG_KEY23:   prdata = cfg.key23;
      chacha_pkg::REG_KEY45:   prdata = cfg.key45;
      chacha_pkg::REG_KEY67:   prdata = cfg.key67;
      chacha_pkg::REG_NONCE01: prdata = cfg.nonce01;
      chacha_pkg::REG_NONCE2:  prdata = {32'd0, cfg.nonce2};
      chacha_pkg::REG_INITCTR: prdata = {32'd0, cfg.init_ctr};
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ src/chacha_core.sv @@
// Keystream block generator: one half quarter round per cycle over a
// 16-word working state, then a feed-forward pass that writes the
// keystream memory one word a cycle. Depends on chacha_pkg.
module chacha_core #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  chacha_pkg::cfg_t     cfg,
  input  chacha_pkg::gen_req_t req,
  output logic                 done,
  output chacha_pkg::ks_wr_t   wr
);

  localparam int unsigned RW = $clog2(DOUBLE_ROUNDS);
  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_ADD   = 2'd2;

  logic [1:0]          state;
  logic [RW-1:0]       rnd;
  logic [2:0]          qr;
  logic                half;
  logic [3:0]          idx;
  logic [31:0]         ctr;
  chacha_pkg::block_t  w;
  chacha_pkg::block_t  init_w;
  logic [3:0]          la, lb, lc, ld;
  logic [127:0]        qr_out;

  assign init_w = chacha_pkg::init_block(cfg, ctr);
  assign la = chacha_pkg::QR_LANES[qr][0];
  assign lb = chacha_pkg::QR_LANES[qr][1];
  assign lc = chacha_pkg::QR_LANES[qr][2];
  assign ld = chacha_pkg::QR_LANES[qr][3];
  assign qr_out = chacha_pkg::qr_half(w[la], w[lb], w[lc], w[ld], half);

  // Feed-forward word into the keystream memory
  assign wr.we   = (state == C_ADD);
  assign wr.addr = idx;
  assign wr.data = w[idx] + init_w[idx];
  assign done    = (state == C_ADD) && (idx == 4'd15);

  // Sequence rounds and feed-forward
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      qr    <= '0;
      half  <= 1'b0;
      idx   <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            state <= C_ROUND;
            rnd   <= '0;
            qr    <= '0;
            half  <= 1'b0;
          end
        end
        C_ROUND: begin
          half <= ~half;
          if (half) begin
            qr <= qr + 3'd1;
            if (qr == 3'd7) begin
              rnd <= rnd + 1'b1;
              if (rnd == RW'(DOUBLE_ROUNDS - 1)) begin
                state <= C_ADD;
                idx   <= '0;
              end
            end
          end
        end
        C_ADD: begin
          idx <= idx + 4'd1;
          if (idx == 4'd15) state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // Working state: load on start, update four lanes per round step
  always_ff @(posedge clk) begin
    if (state == C_IDLE && req.start) begin
      ctr <= req.counter;
      w   <= chacha_pkg::init_block(cfg, req.counter);
    end else if (state == C_ROUND) begin
      w[la] <= qr_out[127:96];
      w[lb] <= qr_out[95:64];
      w[lc] <= qr_out[63:32];
      w[ld] <= qr_out[31:0];
    end
  end

endmodule

@@ src/chacha20_stream_cipher.sv @@
// ChaCha20 stream cipher top level: stream control and keystream memory.
// A request at byte position 0 also makes a block: the rounds run in the shared
// half-quarter-round unit, then feed-forward writes fill the keystream memory.
// One request at a time; the next waits until the last result is handed off.
// Reset: synchronous; clears position, counter, config regs and handshake.
module chacha20_stream_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] starts_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_GEN  = 2'd1;
  localparam logic [1:0] T_READ = 2'd2;
  localparam logic [1:0] T_DATA = 2'd3;

  chacha_pkg::cfg_t     cfg;
  chacha_pkg::gen_req_t req;
  chacha_pkg::ks_wr_t   wr;
  logic                 done;

  logic [1:0]  state;
  logic [5:0]  pos;
  logic [31:0] block_count;
  logic [5:0]  cur_pos;
  logic [7:0]  cur_byte;
  logic [31:0] rd;
  logic [31:0] ks_mem [16];
  logic        accept;
  logic [5:0]  p;
  logic [31:0] bc;

  chacha_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk, .rst, .cfg, .req, .done, .wr
  );

  assign s_tready = (state == T_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;
  assign p        = s_tuser ? 6'd0 : pos;
  assign bc       = s_tuser ? cfg.init_ctr : block_count;
  assign req.start   = accept && (p == 6'd0);
  assign req.counter = bc;

  // Keystream memory: written by the core, read through a registered output
  always_ff @(posedge clk) begin
    if (wr.we) ks_mem[wr.addr] <= wr.data;
    rd <= ks_mem[cur_pos[5:2]];
  end

  // Hold the request payload and register the output byte
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pos  <= p;
      cur_byte <= s_tdata;
    end
    if (state == T_DATA) m_tdata <= cur_byte ^ rd[{cur_pos[1:0], 3'd0} +: 8];
  end

  // Stream control: advance position and counter, drive the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      pos         <= '0;
      block_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            pos <= p + 6'd1;
            if (p == 6'd0) begin
              block_count <= bc + 32'd1;
              state       <= T_GEN;
            end else begin
              block_count <= bc;
              state       <= T_READ;
            end
          end
        end
        T_GEN:  if (done) state <= T_READ;
        T_READ: state <= T_DATA;
        T_DATA: begin
          m_tvalid <= 1'b1;
          state    <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_gen_on_block_start: assert property (@(posedge clk) disable iff (rst)
    req.start |=> state == T_GEN) else $error("block start did not enter generation");
  a_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    done |-> state == T_GEN) else $error("core finished outside generation");
  a_data_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == T_DATA |=> m_tvalid) else $error("result not presented");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready) else $error("second request taken while busy");

endmodule

@@ tb/sv/chacha20_stream_cipher_test.sv @@
// Self-checking testbench for the ChaCha20 stream cipher: APB register writes,
// byte streams with random idling, results checked against a built-in predictor.
// Depends on chacha_pkg and chacha20_stream_cipher.
module chacha20_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  chacha20_stream_cipher u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Predictor copy of the registers and the cipher state
  logic [63:0] key_reg [4];
  logic [63:0] nonce01_reg;
  logic [31:0] nonce2_reg;
  logic [31:0] init_ctr_reg;
  logic [15:0][31:0] ks_words;
  logic [5:0]  ks_pos;
  logic [31:0] blk_ctr;

  logic [7:0]  expected_bytes [$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;
  int unsigned stall_cycles = 0;

  function automatic logic [31:0] rotl(logic [31:0] v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic void quarter_round(inout logic [31:0] a, inout logic [31:0] b,
                                        inout logic [31:0] c, inout logic [31:0] d);
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
  endfunction

  // Make one keystream block for the given counter
  function automatic logic [15:0][31:0] keystream_block(logic [31:0] ctr);
    logic [31:0] st [16];
    logic [31:0] w [16];
    logic [15:0][31:0] blk;
    st[0] = 32'h61707865; st[1] = 32'h3320646e;
    st[2] = 32'h79622d32; st[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      st[4 + 2 * i] = key_reg[i][31:0];
      st[5 + 2 * i] = key_reg[i][63:32];
    end
    st[12] = ctr;
    st[13] = nonce01_reg[31:0];
    st[14] = nonce01_reg[63:32];
    st[15] = nonce2_reg;
    w = st;
    for (int r = 0; r < 10; r++) begin
      quarter_round(w[0], w[4], w[8], w[12]);
      quarter_round(w[1], w[5], w[9], w[13]);
      quarter_round(w[2], w[6], w[10], w[14]);
      quarter_round(w[3], w[7], w[11], w[15]);
      quarter_round(w[0], w[5], w[10], w[15]);
      quarter_round(w[1], w[6], w[11], w[12]);
      quarter_round(w[2], w[7], w[8], w[13]);
      quarter_round(w[3], w[4], w[9], w[14]);
    end
    for (int i = 0; i < 16; i++) blk[i] = w[i] + st[i];
    return blk;
  endfunction

  // Advance the cipher state by one byte and return the expected output
  function automatic logic [7:0] cipher_byte(logic [7:0] data, logic start);
    logic [31:0] word;
    if (start) begin
      ks_pos = '0;
      blk_ctr = init_ctr_reg;
    end
    if (ks_pos == 0) begin
      ks_words = keystream_block(blk_ctr);
      blk_ctr = blk_ctr + 32'd1;
    end
    word = ks_words[ks_pos[5:2]];
    cipher_byte = data ^ word[ks_pos[1:0] * 8 +: 8];
    ks_pos = ks_pos + 6'd1;
  endfunction

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(0, 99) < 29);
  endfunction

  // Send one request, holding valid until it is taken
  task automatic send_byte(logic [7:0] data, logic start);
    logic [7:0] want_byte;
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    want_byte = cipher_byte(data, start);
    expected_bytes.insert(expected_bytes.size(), want_byte);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait for every result to drain
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (expected_bytes.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle
  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      chacha_pkg::REG_KEY01:   key_reg[0] = value;
      chacha_pkg::REG_KEY23:   key_reg[1] = value;
      chacha_pkg::REG_KEY45:   key_reg[2] = value;
      chacha_pkg::REG_KEY67:   key_reg[3] = value;
      chacha_pkg::REG_NONCE01: nonce01_reg = value;
      chacha_pkg::REG_NONCE2:  nonce2_reg = value[31:0];
      chacha_pkg::REG_INITCTR: init_ctr_reg = value[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                           logic [63:0] k3, logic [63:0] n01, logic [31:0] n2,
                           logic [31:0] ctr);
    reg_write(chacha_pkg::REG_KEY01, k0);
    reg_write(chacha_pkg::REG_KEY23, k1);
    reg_write(chacha_pkg::REG_KEY45, k2);
    reg_write(chacha_pkg::REG_KEY67, k3);
    reg_write(chacha_pkg::REG_NONCE01, n01);
    reg_write(chacha_pkg::REG_NONCE2, {32'd0, n2});
    reg_write(chacha_pkg::REG_INITCTR, {32'd0, ctr});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Bytes straight after reset with no message start: zero key, counter 0
  task automatic test_after_reset();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    drain();
  endtask

  // Known key and nonce, message start, mid-stream restart, ignored register
  task automatic test_directed_config();
    write_all(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908, 64'h17161514_13121110,
              64'h1f1e1d1c_1b1a1918, 64'h4a000000_09000000, 32'h0, 32'h1);
    reg_write(REG_UNUSED, 64'hFFFFFFFF_FFFFFFFF);
    send_byte(8'h4c, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    drain();
  endtask

  // Counter wraps from all ones to zero across block boundaries
  task automatic test_counter_wrap();
    write_all('1, '1, '1, '1, '1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    for (int i = 0; i < 140; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
    drain();
    write_all('0, '0, '0, '0, '0, 32'h0, 32'hFFFFFFFE);
    for (int i = 0; i < 140; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
    drain();
  endtask

  // Random messages under several random register settings
  task automatic test_random_messages(int phases, int bytes_per_phase);
    int sent;
    int len;
    for (int p = 0; p < phases; p++) begin
      write_all(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, $urandom);
      no_idle = (p == 1);
      sent = 0;
      while (sent < bytes_per_phase) begin
        // mostly short messages, a few long ones, some with no start marker
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 70);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom_range(0, 255)),
                    (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0));
        end
        sent += len;
      end
      drain();
      no_idle = 1'b0;
    end
  endtask

  // Receiver idling
  always @(posedge clk) begin
    m_tready <= !idle_roll();
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %02h", m_tdata);
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("out_byte mismatch: expected %02h actual %02h",
                                         want, m_tdata);
        end
      end
    end
  end

  // Watchdog: count cycles with work pending and no handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && expected_bytes.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce01_reg = '0;
    nonce2_reg = '0;
    init_ctr_reg = '0;
    ks_words = '0;
    ks_pos = '0;
    blk_ctr = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_directed_config();
    test_counter_wrap();
    test_random_messages(6, 220);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
